// File: design/cpfm_pkg.sv
// Shared types and constants for the character-class first-match search.
// Used by every module of the block; depends on nothing else.
package cpfm_pkg;

   localparam int MAX_ELEMENTS  = 16;
   localparam int ELEM_BITS     = $clog2(MAX_ELEMENTS);
   localparam int LEN_BITS      = 5;
   localparam int POS_BITS      = 16;
   localparam int OUT_POS_BITS  = 16;
   localparam int CHAR_BITS     = 8;
   localparam int CLASS_BITS    = 3;
   localparam int CHAR_COUNT    = 1 << CHAR_BITS;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR     = $clog2(QUEUE_DEPTH);

   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   // Element classes
   localparam logic [CLASS_BITS-1:0] CLS_ANY_OF  = 3'd0;
   localparam logic [CLASS_BITS-1:0] CLS_NONE_OF = 3'd1;
   localparam logic [CLASS_BITS-1:0] CLS_LOWER   = 3'd2;
   localparam logic [CLASS_BITS-1:0] CLS_UPPER   = 3'd3;
   localparam logic [CLASS_BITS-1:0] CLS_ALNUM   = 3'd4;

   // ASCII bounds
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_DIGIT_9 = 8'h39;

   // Item kinds, as they arrive on the input channel
   typedef enum logic [1:0] {
      OP_SET_CLASS = 2'd0,
      OP_ADD_MEMBER = 2'd1,
      OP_TEXT = 2'd2,
      OP_END = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [ELEM_BITS-1:0]   idx;
      logic [CLASS_BITS-1:0]  cls;
      logic [CHAR_BITS-1:0]   ch;
   } q_entry_type;

   typedef struct packed {
      logic pop;
      logic init;
   } back_ctrl_type;

endpackage

// File: design/cpfm_set_mem.sv
// Member-set memory: one row per byte value, one bit per pattern element.
// Bit-masked single write port, one registered read port; uses cpfm_pkg.
module cpfm_set_mem (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [cpfm_pkg::CHAR_BITS-1:0]        wr_addr,
   input  logic [cpfm_pkg::MAX_ELEMENTS-1:0]     wr_mask,
   input  logic                                  wr_value,
   input  logic                                  rd_en,
   input  logic [cpfm_pkg::CHAR_BITS-1:0]        rd_addr,
   output logic [cpfm_pkg::MAX_ELEMENTS-1:0]     rd_data
);
   import cpfm_pkg::*;

   logic [MAX_ELEMENTS-1:0] mem [CHAR_COUNT];
   logic [MAX_ELEMENTS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < MAX_ELEMENTS; b++) begin
            if (wr_mask[b]) begin
               mem[wr_addr][b] <= wr_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/cpfm_front.sv
// Front end: accepts input items, decodes their kind and queues them.
// Feeds the back end through a short queue; uses cpfm_pkg.
module cpfm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [15:0]              req_tdata,
   input  logic [1:0]               req_tuser,
   input  cpfm_pkg::back_ctrl_type  ctrl,
   output cpfm_pkg::q_entry_type    head,
   output logic                     head_valid
);
   import cpfm_pkg::*;

   q_entry_type            q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR:0]     count_ff, count_in;
   q_entry_type            entry;
   logic                   push;

   always_comb begin
      entry.op  = op_type'(req_tuser);
      entry.idx = req_tdata[ELEM_BITS-1:0];
      entry.cls = req_tdata[6:4];
      entry.ch  = req_tdata[14:7];
   end

   assign req_tready = (count_ff != (QUEUE_PTR+1)'(QUEUE_DEPTH)) && !ctrl.init;
   assign push       = req_tvalid && req_tready;
   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = ctrl.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR+1)'(push) - (QUEUE_PTR+1)'(ctrl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// File: design/cpfm_back.sv
// Back end: applies pattern updates, sweeps cleared sets and runs the
// shift-and chain over text bytes; holds the result register. Uses cpfm_pkg.
module cpfm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  cpfm_pkg::q_entry_type               head,
   input  logic                                head_valid,
   input  logic [cpfm_pkg::LEN_BITS-1:0]       active_len,
   output cpfm_pkg::back_ctrl_type             ctrl,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,
   output logic                                rsp_tuser
);
   import cpfm_pkg::*;

   // pattern classes
   logic [CLASS_BITS-1:0]   class_ff [MAX_ELEMENTS];

   // set clearing sweep
   logic                    sweep_ff, sweep_in;
   logic                    init_ff, init_in;
   logic [CHAR_BITS-1:0]    sweep_addr_ff, sweep_addr_in;
   logic [MAX_ELEMENTS-1:0] sweep_mask_ff, sweep_mask_in;

   // evaluation stage
   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_end_ff;
   logic [CHAR_BITS-1:0]    s2_ch_ff;
   logic [CLASS_BITS-1:0]   s2_cls_ff [MAX_ELEMENTS];

   // search state
   logic [MAX_ELEMENTS-1:0] prefix_ff, prefix_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic                    reported_ff, reported_in;

   // result register
   logic                    out_valid_ff, out_valid_in;
   logic                    out_found_ff;
   logic [OUT_POS_BITS-1:0] out_start_ff;
   logic [LEN_BITS-1:0]     out_len_ff;

   logic                    pop, to_s2, s2_fire, s2_result, hit;
   logic                    mem_wr_en, mem_wr_value, mem_rd_en;
   logic [CHAR_BITS-1:0]    mem_wr_addr;
   logic [MAX_ELEMENTS-1:0] mem_wr_mask, member_bits, accept, lane_mask, prefix_calc;
   logic                    is_lower, is_upper, is_digit;
   logic [LEN_BITS-1:0]     len_m1;
   logic [POS_BITS-1:0]     start_calc;

   cpfm_set_mem u_set_mem (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_mask  (mem_wr_mask),
      .wr_value (mem_wr_value),
      .rd_en    (mem_rd_en),
      .rd_addr  (head.ch),
      .rd_data  (member_bits)
   );

   // ---------------- evaluation of the item in stage two ----------------
   always_comb begin
      is_lower = (s2_ch_ff >= CH_LOWER_A) && (s2_ch_ff <= CH_LOWER_Z);
      is_upper = (s2_ch_ff >= CH_UPPER_A) && (s2_ch_ff <= CH_UPPER_Z);
      is_digit = (s2_ch_ff >= CH_DIGIT_0) && (s2_ch_ff <= CH_DIGIT_9);
      len_m1   = active_len - 1'b1;
      for (int e = 0; e < MAX_ELEMENTS; e++) begin
         lane_mask[e] = (LEN_BITS'(e) < active_len);
         case (s2_cls_ff[e])
            CLS_ANY_OF:  accept[e] = member_bits[e];
            CLS_NONE_OF: accept[e] = !member_bits[e];
            CLS_LOWER:   accept[e] = is_lower;
            CLS_UPPER:   accept[e] = is_upper;
            CLS_ALNUM:   accept[e] = is_lower || is_upper || is_digit;
            default:     accept[e] = 1'b0;
         endcase
      end
      prefix_calc = {prefix_ff[MAX_ELEMENTS-2:0], 1'b1} & accept & lane_mask;
      hit         = prefix_calc[len_m1[ELEM_BITS-1:0]];
      if (pos_ff == POS_MAX) begin
         start_calc = POS_MAX;
      end else if (pos_ff >= POS_BITS'(len_m1)) begin
         start_calc = pos_ff - POS_BITS'(len_m1);
      end else begin
         start_calc = '0;
      end
      s2_result = s2_valid_ff && !reported_ff && (s2_end_ff || hit);
      s2_fire   = s2_valid_ff && (!s2_result || !out_valid_ff || rsp_tready);
   end

   // ---------------- issue from the queue head ----------------
   always_comb begin
      to_s2 = (head.op == OP_TEXT) || (head.op == OP_END);
      pop   = head_valid && !sweep_ff && (!to_s2 || !s2_valid_ff || s2_fire);
      mem_rd_en = pop && (head.op == OP_TEXT);
      if (sweep_ff) begin
         mem_wr_en    = 1'b1;
         mem_wr_addr  = sweep_addr_ff;
         mem_wr_mask  = sweep_mask_ff;
         mem_wr_value = 1'b0;
      end else begin
         mem_wr_en    = pop && (head.op == OP_ADD_MEMBER);
         mem_wr_addr  = head.ch;
         mem_wr_mask  = MAX_ELEMENTS'(1) << head.idx;
         mem_wr_value = 1'b1;
      end
   end

   assign ctrl.pop  = pop;
   assign ctrl.init = init_ff;

   // ---------------- next-state logic ----------------
   always_comb begin
      sweep_in      = sweep_ff;
      init_in       = init_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_mask_in = sweep_mask_ff;
      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == CHAR_BITS'(CHAR_COUNT - 1)) begin
            sweep_in = 1'b0;
            init_in  = 1'b0;
         end
      end else if (pop && (head.op == OP_SET_CLASS)) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
         sweep_mask_in = MAX_ELEMENTS'(1) << head.idx;
      end

      if (pop && to_s2) begin
         s2_valid_in = 1'b1;
      end else if (s2_fire) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end

      prefix_in   = prefix_ff;
      pos_in      = pos_ff;
      reported_in = reported_ff;
      if (s2_fire) begin
         if (s2_end_ff) begin
            prefix_in   = '0;
            pos_in      = '0;
            reported_in = 1'b0;
         end else if (!reported_ff) begin
            prefix_in = prefix_calc;
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 1'b1;
            end
            if (hit) begin
               reported_in = 1'b1;
            end
         end
      end

      if (s2_fire && s2_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         init_ff       <= 1'b1;
         sweep_addr_ff <= '0;
         sweep_mask_ff <= '1;
         s2_valid_ff   <= 1'b0;
         prefix_ff     <= '0;
         pos_ff        <= '0;
         reported_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int e = 0; e < MAX_ELEMENTS; e++) begin
            class_ff[e] <= CLS_ANY_OF;
         end
      end else begin
         sweep_ff      <= sweep_in;
         init_ff       <= init_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_mask_ff <= sweep_mask_in;
         s2_valid_ff   <= s2_valid_in;
         prefix_ff     <= prefix_in;
         pos_ff        <= pos_in;
         reported_ff   <= reported_in;
         out_valid_ff  <= out_valid_in;
         if (pop && (head.op == OP_SET_CLASS)) begin
            class_ff[head.idx] <= head.cls;
         end
      end
   end

   // stage-two payload: snapshot the classes so later updates do not leak in
   always_ff @(posedge clock) begin
      if (pop && to_s2) begin
         s2_end_ff <= (head.op == OP_END);
         s2_ch_ff  <= head.ch;
         for (int e = 0; e < MAX_ELEMENTS; e++) begin
            s2_cls_ff[e] <= class_ff[e];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire && s2_result) begin
         out_found_ff <= !s2_end_ff;
         out_start_ff <= s2_end_ff ? '0 : start_calc[OUT_POS_BITS-1:0];
         out_len_ff   <= s2_end_ff ? '0 : active_len;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = {3'b000, out_len_ff, out_start_ff};

   // ---------------- assertions ----------------
   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !pop)
      else $error("item taken from queue during set clearing after reset");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !(s2_fire && s2_result))
      else $error("result register overwritten while stalled");

   a_hit_marks_reported: assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s2_result && !s2_end_ff) |=> reported_ff)
      else $error("match reported but search not closed");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (sweep_ff && (sweep_addr_ff == CHAR_BITS'(CHAR_COUNT - 1))) |=> !sweep_ff)
      else $error("set clearing sweep did not stop at last row");

   a_end_rearms: assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s2_end_ff) |=> (pos_ff == '0 && prefix_ff == '0))
      else $error("end of text did not rearm the search");

endmodule

// File: design/class_pattern_first_match.sv
// Top level of the character-class first-match search: pattern length
// register, front end, back end. Depends on cpfm_pkg, cpfm_front, cpfm_back.
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  tdata: index, class, byte; tuser: kind
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: start, length; tuser: found
//   csr_      in         csr_valid/csr_ready    csr_data: pattern length
//
// One item per cycle for text and end-of-text items unless a sweep or a stalled result
// holds them: every element's prefix bit updates in parallel from one set memory read.
// Between accepting an item and rsp_tvalid lie the queue entry, the set memory read and
// the stage-two registers, and the result register.
// An element class item clears that element's set with a sweep over all 256 rows of
// the set memory; items behind it wait in the queue.
// After reset a clearing pass over all 256 set memory rows runs with req_tready
// low; configuration writes are taken throughout.
// A stalled result holds in the output register while up to four items queue.
module class_pattern_first_match (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] element_index, [6:4] element_class,
                                    // [14:7] char_value, [15] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] match_start, [20:16] match_length,
                                    // [23:21] zero
   output logic        rsp_tuser,   // [0] found
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // [4:0] pattern_length
);
   import cpfm_pkg::*;

   logic [LEN_BITS-1:0] len_ff;
   logic [LEN_BITS-1:0] active_len;
   back_ctrl_type       ctrl;
   q_entry_type         head;
   logic                head_valid;

   // User writes must come only while the block is idle; not enforced, always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         len_ff <= csr_data;
      end
   end

   // Clamp the length: zero acts as one, anything above the element count
   // acts as the full element count.
   always_comb begin
      if (len_ff == '0) begin
         active_len = LEN_BITS'(1);
      end else if (len_ff > LEN_BITS'(MAX_ELEMENTS)) begin
         active_len = LEN_BITS'(MAX_ELEMENTS);
      end else begin
         active_len = len_ff;
      end
   end

   // Front: accept, decode kind, queue.
   cpfm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ctrl       (ctrl),
      .head       (head),
      .head_valid (head_valid)
   );

   // Back: pattern updates, set sweeps, shift-and chain, result register.
   cpfm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .active_len (active_len),
      .ctrl       (ctrl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
